// ===== hw/rtl/qmmsl_pkg.sv =====
// ============================================================================
// qmmsl_pkg
// Shared types and constants for the quad motor mixer with slew limiting.
// ============================================================================
package qmmsl_pkg;

    localparam int SPD_W      = 10;
    localparam int ACC_W      = 15;
    localparam int DELTA_W    = 11;
    localparam int DUTY_W     = 10;
    localparam int MOTORS_DEF = 4;
    localparam int QDEPTH     = 2;

    localparam logic [SPD_W-1:0] SPEED_MAX = 10'd1000;
    localparam logic [5:0]       RAMP_RST  = 6'd25;
    localparam logic [5:0]       RAMP_MIN  = 6'd1;
    localparam logic [5:0]       RAMP_MAX  = 6'd50;
    localparam logic [7:0]       GAIN_RST  = 8'd50;

    // duty = floor((1000 + speed) * 8191 / 20000) = ((1000 + speed) * DUTY_K) >> DUTY_SH
    localparam logic [10:0] PWM_OFFS = 11'd1000;
    localparam logic [24:0] DUTY_K   = 25'd27484436;
    localparam int          DUTY_SH  = 26;

    typedef enum logic [1:0] {
        ACT_CMD  = 2'd0,
        ACT_ADJ  = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_RAMP  = 2'd0,
        CFG_GAIN  = 2'd1,
        CFG_ROLL  = 2'd2,
        CFG_PITCH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [5:0] ramp;
        logic [7:0] gain;
        logic [3:0] roll;
        logic [3:0] pitch;
    } t_cfg;

    typedef struct packed {
        logic [SPD_W-1:0]        coll;
        logic                    correct;
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
    } t_tick;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROD,
        BK_SLEW,
        BK_DUTY,
        BK_OUT
    } t_back_state;

endpackage

// ===== hw/rtl/qmmsl_front.sv =====
// ============================================================================
// qmmsl_front
// Accepts event beats, keeps collective and stabilize state, queues ticks.
// ============================================================================
module qmmsl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic                          i_arm,
    input  logic                          i_stab,
    input  logic [qmmsl_pkg::SPD_W-1:0]   i_thr,
    input  logic signed [qmmsl_pkg::DELTA_W-1:0] i_delta,
    input  logic signed [qmmsl_pkg::ACC_W-1:0]   i_ax,
    input  logic signed [qmmsl_pkg::ACC_W-1:0]   i_ay,
    input  logic                          i_imu_valid,
    input  qmmsl_pkg::t_q_status          i_q_status,
    output logic                          o_push,
    output qmmsl_pkg::t_tick              o_push_data
);

    logic [qmmsl_pkg::SPD_W-1:0] r_coll, n_coll;
    logic                        r_stab, n_stab;
    logic                        accept;
    logic [qmmsl_pkg::SPD_W-1:0] thr_sat;
    logic signed [11:0]          adj_sum;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    assign thr_sat = (i_thr > qmmsl_pkg::SPEED_MAX) ? qmmsl_pkg::SPEED_MAX : i_thr;
    assign adj_sum = $signed({2'b00, r_coll}) + $signed({i_delta[qmmsl_pkg::DELTA_W-1], i_delta});

    always_comb begin
        n_coll = r_coll;
        n_stab = r_stab;
        o_push = 1'b0;
        if (accept) begin
            unique case (qmmsl_pkg::t_action'(i_action))
                qmmsl_pkg::ACT_CMD: begin
                    n_stab = i_stab;
                    n_coll = i_arm ? thr_sat : '0;
                end
                qmmsl_pkg::ACT_ADJ: begin
                    if (adj_sum < 12'sd0) begin
                        n_coll = '0;
                    end else if (adj_sum > $signed({2'b00, qmmsl_pkg::SPEED_MAX})) begin
                        n_coll = qmmsl_pkg::SPEED_MAX;
                    end else begin
                        n_coll = adj_sum[qmmsl_pkg::SPD_W-1:0];
                    end
                end
                qmmsl_pkg::ACT_TICK: begin
                    o_push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // snapshot of collective and correction enable travels with the tick
    assign o_push_data.coll    = r_coll;
    assign o_push_data.correct = r_stab && (r_coll != '0) && i_imu_valid;
    assign o_push_data.ax      = i_ax;
    assign o_push_data.ay      = i_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll <= '0;
            r_stab <= 1'b1;
        end else begin
            r_coll <= n_coll;
            r_stab <= n_stab;
        end
    end

endmodule

// ===== hw/rtl/qmmsl_queue.sv =====
// ============================================================================
// qmmsl_queue
// Short tick queue between the front and the back.
// ============================================================================
module qmmsl_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qmmsl_pkg::t_tick     i_push_data,
    input  logic                 i_pop,
    output qmmsl_pkg::t_tick     o_head,
    output qmmsl_pkg::t_q_status o_status
);

    localparam int QAW = (qmmsl_pkg::QDEPTH > 1) ? $clog2(qmmsl_pkg::QDEPTH) : 1;

    qmmsl_pkg::t_tick r_mem [qmmsl_pkg::QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QAW:0]     r_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == (QAW+1)'(qmmsl_pkg::QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(qmmsl_pkg::QDEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(qmmsl_pkg::QDEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/qmmsl_back.sv =====
// ============================================================================
// qmmsl_back
// Per-motor sequencer: tilt product, target and slew, duty, result beat.
// ============================================================================
module qmmsl_back #(
    parameter int MOTORS = qmmsl_pkg::MOTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qmmsl_pkg::t_cfg               i_cfg,
    input  qmmsl_pkg::t_tick              i_head,
    input  qmmsl_pkg::t_q_status          i_q_status,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_index,
    output logic [qmmsl_pkg::SPD_W-1:0]   o_speed,
    output logic [qmmsl_pkg::DUTY_W-1:0]  o_duty,
    output logic                          o_last
);

    localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    qmmsl_pkg::t_back_state r_state, n_state;
    qmmsl_pkg::t_tick       r_tick;
    logic [MW-1:0]          r_motor;
    logic signed [25:0]     r_prod;
    logic [10:0]            r_y;
    logic [qmmsl_pkg::SPD_W-1:0] r_speed [MOTORS];

    logic r_out_valid, r_out_last;
    logic [1:0]                   r_out_index;
    logic [qmmsl_pkg::SPD_W-1:0]  r_out_speed;
    logic [qmmsl_pkg::DUTY_W-1:0] r_out_duty;

    logic ld_prod, ld_slew, ld_out, out_take, is_last;
    logic [7:0]        roll_ext, pitch_ext;
    logic [MOTORS-1:0] rsign, psign;

    // product stage
    logic signed [16:0] sum;
    logic signed [25:0] prod;
    // slew stage
    logic [25:0]        mag;
    logic [15:0]        qv;
    logic signed [17:0] corr, tsum;
    logic [qmmsl_pkg::SPD_W-1:0] tgt, cur, new_spd;
    logic [10:0]        up, tgt_p;
    // duty stage
    logic [35:0]        dprod;

    assign roll_ext  = {4'b0000, i_cfg.roll};
    assign pitch_ext = {4'b0000, i_cfg.pitch};

    always_comb begin
        for (int m = 0; m < MOTORS; m++) begin
            rsign[m] = roll_ext[m];
            psign[m] = pitch_ext[m];
        end
    end

    assign is_last  = (r_motor == MW'(MOTORS-1));
    assign out_take = r_out_valid && i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qmmsl_pkg::BK_IDLE: if (!i_q_status.empty) n_state = qmmsl_pkg::BK_PROD;
            qmmsl_pkg::BK_PROD: n_state = qmmsl_pkg::BK_SLEW;
            qmmsl_pkg::BK_SLEW: n_state = qmmsl_pkg::BK_DUTY;
            qmmsl_pkg::BK_DUTY: n_state = qmmsl_pkg::BK_OUT;
            qmmsl_pkg::BK_OUT: begin
                if (out_take) n_state = is_last ? qmmsl_pkg::BK_IDLE : qmmsl_pkg::BK_PROD;
            end
            default: n_state = qmmsl_pkg::BK_IDLE;
        endcase
    end

    // strobes
    always_comb begin
        o_pop   = 1'b0;
        ld_prod = 1'b0;
        ld_slew = 1'b0;
        ld_out  = 1'b0;
        unique case (r_state)
            qmmsl_pkg::BK_IDLE: o_pop   = !i_q_status.empty;
            qmmsl_pkg::BK_PROD: ld_prod = 1'b1;
            qmmsl_pkg::BK_SLEW: ld_slew = 1'b1;
            qmmsl_pkg::BK_DUTY: ld_out  = 1'b1;
            qmmsl_pkg::BK_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // gain * (+-ay +-ax)
    always_comb begin
        sum  = (rsign[r_motor] ? 17'(r_tick.ay) : -17'(r_tick.ay))
             + (psign[r_motor] ? 17'(r_tick.ax) : -17'(r_tick.ax));
        prod = $signed({1'b0, i_cfg.gain}) * sum;
    end

    // correction = -(prod) / 1024 toward zero, then clamp and slew
    always_comb begin
        mag  = r_prod[25] ? 26'(-r_prod) : 26'(r_prod);
        qv   = mag[25:10];
        corr = r_prod[25] ? $signed({2'b00, qv}) : -$signed({2'b00, qv});
        tsum = $signed({8'b0, r_tick.coll}) + corr;
        if (!r_tick.correct) begin
            tgt = r_tick.coll;
        end else if (tsum < 18'sd0) begin
            tgt = '0;
        end else if (tsum > $signed({8'b0, qmmsl_pkg::SPEED_MAX})) begin
            tgt = qmmsl_pkg::SPEED_MAX;
        end else begin
            tgt = tsum[qmmsl_pkg::SPD_W-1:0];
        end
        cur   = r_speed[r_motor];
        up    = {1'b0, cur} + {5'b0, i_cfg.ramp};
        tgt_p = {1'b0, tgt} + {5'b0, i_cfg.ramp};
        if (cur < tgt) begin
            new_spd = (up > {1'b0, tgt}) ? tgt : up[qmmsl_pkg::SPD_W-1:0];
        end else if (cur > tgt) begin
            new_spd = ({1'b0, cur} > tgt_p) ? cur - {4'b0, i_cfg.ramp} : tgt;
        end else begin
            new_spd = cur;
        end
    end

    assign dprod = {25'b0, r_y} * {11'b0, qmmsl_pkg::DUTY_K};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tick <= i_head;
        end
        if (ld_prod) begin
            r_prod <= prod;
        end
        if (ld_slew) begin
            r_y <= qmmsl_pkg::PWM_OFFS + {1'b0, new_spd};
        end
        if (ld_out) begin
            r_out_index <= 2'(r_motor);
            r_out_speed <= r_speed[r_motor];
            r_out_duty  <= dprod[qmmsl_pkg::DUTY_SH +: qmmsl_pkg::DUTY_W];
            r_out_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qmmsl_pkg::BK_IDLE;
            r_motor     <= '0;
            r_out_valid <= 1'b0;
            for (int m = 0; m < MOTORS; m++) begin
                r_speed[m] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_motor <= '0;
            end else if (out_take && !is_last) begin
                r_motor <= r_motor + 1'b1;
            end
            if (ld_slew) begin
                r_speed[r_motor] <= new_spd;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_index = r_out_index;
    assign o_speed = r_out_speed;
    assign o_duty  = r_out_duty;
    assign o_last  = r_out_last;

endmodule

// ===== hw/rtl/quad_motor_mixer_slew_limiter.sv =====
// ============================================================================
// quad_motor_mixer_slew_limiter
// Motor mixer with tilt correction and per-tick slew limiting, stream I/O.
// ============================================================================
// The front takes one event beat per cycle while its two-entry tick queue has
// room: flight commands and power adjusts update the collective at once and
// produce no result; control ticks are queued with a snapshot of the
// collective and the correction enable. The back works one tick at a time,
// one motor after another, through the steps tilt product, target clamp and
// slew, duty multiply and result beat for each motor, after a step that takes
// the tick off the queue; the result beat waits for the downstream side. The
// back's per-motor multiplier chain is shared by all motors. Configuration
// writes are always accepted (o_cfg_ready is tied high) and should only be
// issued while the block is idle.
// ============================================================================
module quad_motor_mixer_slew_limiter #(
    parameter int MOTORS = qmmsl_pkg::MOTORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] arm, [1] stabilize_request, [11:2] throttle_level,
    // [22:12] power_delta, [37:23] accel_x, [52:38] accel_y, [53] imu_valid
    input  logic [55:0] i_s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  i_s_axis_tuser,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] motor_index, [11:2] motor_speed, [21:12] pwm_duty
    output logic [23:0] o_m_axis_tdata,
    // last_motor
    output logic        o_m_axis_tlast,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    qmmsl_pkg::t_cfg      r_cfg;
    qmmsl_pkg::t_tick     w_push_data, w_head;
    qmmsl_pkg::t_q_status w_q_status;
    logic                 w_push, w_pop;
    logic [1:0]           w_index;
    logic [qmmsl_pkg::SPD_W-1:0]  w_speed;
    logic [qmmsl_pkg::DUTY_W-1:0] w_duty;
    logic [5:0]           cfg_ramp_raw;

    // ------------------------------------------------------------------
    // Config registers; ramp rate saturates to 1..50 on write
    // ------------------------------------------------------------------
    assign o_cfg_ready  = 1'b1;
    assign cfg_ramp_raw = i_cfg_data[5:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp  <= qmmsl_pkg::RAMP_RST;
            r_cfg.gain  <= qmmsl_pkg::GAIN_RST;
            r_cfg.roll  <= '0;
            r_cfg.pitch <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (qmmsl_pkg::t_cfg_idx'(i_cfg_index))
                qmmsl_pkg::CFG_RAMP: begin
                    if (cfg_ramp_raw < qmmsl_pkg::RAMP_MIN) begin
                        r_cfg.ramp <= qmmsl_pkg::RAMP_MIN;
                    end else if (cfg_ramp_raw > qmmsl_pkg::RAMP_MAX) begin
                        r_cfg.ramp <= qmmsl_pkg::RAMP_MAX;
                    end else begin
                        r_cfg.ramp <= cfg_ramp_raw;
                    end
                end
                qmmsl_pkg::CFG_GAIN:  r_cfg.gain  <= i_cfg_data;
                qmmsl_pkg::CFG_ROLL:  r_cfg.roll  <= i_cfg_data[3:0];
                qmmsl_pkg::CFG_PITCH: r_cfg.pitch <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front: event decode and collective state
    // ------------------------------------------------------------------
    qmmsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_arm       (i_s_axis_tdata[0]),
        .i_stab      (i_s_axis_tdata[1]),
        .i_thr       (i_s_axis_tdata[11:2]),
        .i_delta     ($signed(i_s_axis_tdata[22:12])),
        .i_ax        ($signed(i_s_axis_tdata[37:23])),
        .i_ay        ($signed(i_s_axis_tdata[52:38])),
        .i_imu_valid (i_s_axis_tdata[53]),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // ------------------------------------------------------------------
    // Tick queue
    // ------------------------------------------------------------------
    qmmsl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    // ------------------------------------------------------------------
    // Back: per-motor mixing, slew and duty
    // ------------------------------------------------------------------
    qmmsl_back #(
        .MOTORS (MOTORS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_index    (w_index),
        .o_speed    (w_speed),
        .o_duty     (w_duty),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_duty, w_speed, w_index};

`ifndef SYNTHESIS
    // Result beats stay inside the speed and duty ranges
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_speed <= qmmsl_pkg::SPEED_MAX))
        else $error("motor speed above maximum");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_duty >= 10'd409) && (w_duty <= 10'd819)))
        else $error("pwm duty out of range");

    // Back only pops a tick that is present
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty tick queue");

    // Front never pushes into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("push into full tick queue");

    // Ramp rate register stays saturated
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cfg.ramp >= qmmsl_pkg::RAMP_MIN) && (r_cfg.ramp <= qmmsl_pkg::RAMP_MAX))
        else $error("ramp rate out of range");
`endif

endmodule
